/* rtl/kwsp_pkg.sv */
// Shared types, constants and keyword tables for the whole-word keyword spotter.
`timescale 1ns / 1ps

package kwsp_pkg;

    // Text geometry and counter limits.
    localparam int TEXT_LEN  = 256;
    localparam int MAX_COUNT = 15;
    localparam int POS_W     = $clog2(TEXT_LEN);
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(TEXT_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);

    // Keywords.
    localparam int NUM_KW = 3;
    localparam logic [1:0] KW_ATTACK  = 2'd0;
    localparam logic [1:0] KW_MALWARE = 2'd1;
    localparam logic [1:0] KW_VIRUS   = 2'd2;

    localparam logic [3:0] CIW_MAX = 4'd15;

    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd7, 4'd5};

    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{8'h41, 8'h54, 8'h54, 8'h41, 8'h43, 8'h4B, 8'h00, 8'h00},  // ATTACK
        '{8'h4D, 8'h41, 8'h4C, 8'h57, 8'h41, 8'h52, 8'h45, 8'h00},  // MALWARE
        '{8'h56, 8'h49, 8'h52, 8'h55, 8'h53, 8'h00, 8'h00, 8'h00}   // VIRUS
    };

    // Special characters.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_EXCL  = 8'h21;
    localparam logic [7:0] CHAR_QUERY = 8'h3F;

    // Event kinds.
    localparam logic EV_MATCH   = 1'b0;
    localparam logic EV_SUMMARY = 1'b1;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int QPTR_W     = $clog2(FIFO_DEPTH);
    localparam int QCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       event_kind;
        logic [1:0] keyword_index;
        logic [7:0] start_position;
        logic [3:0] occurrence;
        logic       none_found;
        logic       last_of_run;
    } t_result;

    // Results raised by one byte: num is 0, 1 or 2, first is taken before second.
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } t_queue_status;

endpackage

/* rtl/whole_word_keyword_spotter_core.sv */
// Top level of the whole-word keyword spotter: handshakes, matcher and result queue.
`timescale 1ns / 1ps

// The core takes one text byte per cycle and reports every whole word equal to
// ATTACK, MALWARE or VIRUS (case-sensitive; space, period, exclamation mark and
// question mark end a word) as a match result carrying the keyword, the start
// position of the word and the running count of that keyword. A zero byte ends
// the text: it closes the last word, adds a summary result that says whether
// any keyword was seen, and returns the matcher to its reset state. Each byte is
// handled in the cycle it is accepted, and results pass through a four-entry
// queue that is drained at one result per cycle while the receiver does not
// stall. A zero byte that completes a keyword raises two results, and the input
// stall is raised whenever the queue holds fewer than two free entries, so a
// request can be accepted on every clock, one byte per cycle, while the output
// side keeps up. The results of a byte are registered in the queue, in order.

module whole_word_keyword_spotter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_event_kind,
    output logic [1:0] o_keyword_index,
    output logic [7:0] o_start_position,
    output logic [3:0] o_occurrence,
    output logic       o_none_found,
    output logic       o_last_of_run
);
    import kwsp_pkg::*;

    logic          accept;
    logic          pop;
    t_push         push;
    t_result       head;
    t_queue_status qstat;

    // Stall while a byte could raise more results than the queue has room for.
    assign o_stall = (qstat.count > QCNT_W'(FIFO_DEPTH - 2));
    assign accept  = i_valid && !o_stall;

    assign o_valid = (qstat.count != '0);
    assign pop     = o_valid && !i_stall;

    kwsp_matcher u_matcher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .o_push      (push)
    );

    kwsp_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (qstat)
    );

    assign o_event_kind     = head.event_kind;
    assign o_keyword_index  = head.keyword_index;
    assign o_start_position = head.start_position;
    assign o_occurrence     = head.occurrence;
    assign o_none_found     = head.none_found;
    assign o_last_of_run    = head.last_of_run;

`ifndef SYNTHESIS
    // The queue never holds more results than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= QCNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // An accepted end-of-text byte always leaves at least a summary waiting.
    a_zero_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_text_byte == CHAR_NUL)) |=> o_valid)
        else $error("end of text produced no result");

    // A result that is not the last of its byte is always a match event.
    a_first_is_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> (o_event_kind == EV_MATCH))
        else $error("summary result not marked last");
`endif

endmodule

/* rtl/kwsp_result_queue.sv */
// Four-entry result queue that takes up to two results per cycle and gives one.
`timescale 1ns / 1ps

module kwsp_result_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  kwsp_pkg::t_push         i_push,
    input  logic                    i_pop,
    output kwsp_pkg::t_result       o_head,
    output kwsp_pkg::t_queue_status o_status
);
    import kwsp_pkg::*;

    t_result           r_mem [FIFO_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] wr_next;

    assign wr_next = r_wr + QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(i_push.num);
            r_rd    <= r_rd + QPTR_W'(i_pop);
            r_count <= r_count + QCNT_W'(i_push.num) - QCNT_W'(i_pop);
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.count = r_count;

endmodule

/* rtl/kwsp_matcher.sv */
// Word tracking state, keyword comparison and result formation for one byte.
`timescale 1ns / 1ps

module kwsp_matcher (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_text_byte,
    output kwsp_pkg::t_push o_push
);
    import kwsp_pkg::*;

    logic [POS_W-1:0] r_byte_position, n_byte_position;
    logic [POS_W-1:0] r_word_start,    n_word_start;
    logic [3:0]       r_char_in_word,  n_char_in_word;
    logic [NUM_KW-1:0] r_match_alive,  n_match_alive;
    logic [CNT_W-1:0] r_counts [NUM_KW];
    logic [CNT_W-1:0] n_counts [NUM_KW];
    logic             r_word_overflow, n_word_overflow;

    logic              is_zero;
    logic              is_end;
    logic [NUM_KW-1:0] hit;
    logic              found;
    logic [1:0]        hit_idx;
    logic              none;
    t_result           match_res;
    t_result           summary_res;

    always_comb begin
        n_byte_position = r_byte_position;
        n_word_start    = r_word_start;
        n_char_in_word  = r_char_in_word;
        n_match_alive   = r_match_alive;
        n_word_overflow = r_word_overflow;
        for (int k = 0; k < NUM_KW; k++) begin
            n_counts[k] = r_counts[k];
        end

        is_zero = (i_text_byte == CHAR_NUL);
        is_end  = is_zero || (i_text_byte == CHAR_SPACE) || (i_text_byte == CHAR_DOT)
                  || (i_text_byte == CHAR_EXCL) || (i_text_byte == CHAR_QUERY);

        for (int k = 0; k < NUM_KW; k++) begin
            hit[k] = r_match_alive[k] && !r_word_overflow && (r_char_in_word == KW_LEN[k]);
        end
        found = |hit;
        priority if (hit[0]) begin
            hit_idx = KW_ATTACK;
        end else if (hit[1]) begin
            hit_idx = KW_MALWARE;
        end else begin
            hit_idx = KW_VIRUS;
        end

        if (is_end && found && (r_counts[hit_idx] < CNT_MAX)) begin
            n_counts[hit_idx] = r_counts[hit_idx] + CNT_W'(1);
        end

        none = 1'b1;
        for (int k = 0; k < NUM_KW; k++) begin
            if (n_counts[k] != '0) begin
                none = 1'b0;
            end
        end

        match_res.event_kind     = EV_MATCH;
        match_res.keyword_index  = hit_idx;
        match_res.start_position = 8'(r_word_start);
        match_res.occurrence     = 4'(n_counts[hit_idx]);
        match_res.none_found     = 1'b0;
        match_res.last_of_run    = !is_zero;

        summary_res.event_kind     = EV_SUMMARY;
        summary_res.keyword_index  = KW_ATTACK;
        summary_res.start_position = 8'd0;
        summary_res.occurrence     = 4'd0;
        summary_res.none_found     = none;
        summary_res.last_of_run    = 1'b1;

        o_push.num    = 2'd0;
        o_push.first  = summary_res;
        o_push.second = summary_res;
        if (i_accept && is_end) begin
            if (found) begin
                o_push.first = match_res;
                o_push.num   = is_zero ? 2'd2 : 2'd1;
            end else if (is_zero) begin
                o_push.num = 2'd1;
            end
        end

        if (is_end) begin
            n_char_in_word  = 4'd0;
            n_match_alive   = '1;
            n_word_overflow = 1'b0;
        end else begin
            if (r_char_in_word == 4'd0 && !r_word_overflow) begin
                n_word_start = r_byte_position;
            end
            for (int k = 0; k < NUM_KW; k++) begin
                if ((r_char_in_word >= KW_LEN[k]) ||
                    (KW_TEXT[k][r_char_in_word[2:0]] != i_text_byte)) begin
                    n_match_alive[k] = 1'b0;
                end
            end
            if (r_char_in_word >= CIW_MAX) begin
                n_word_overflow = 1'b1;
            end else begin
                n_char_in_word = r_char_in_word + 4'd1;
            end
        end

        if (is_zero) begin
            // End of text: everything returns to its reset value.
            n_byte_position = '0;
            n_word_start    = '0;
            for (int k = 0; k < NUM_KW; k++) begin
                n_counts[k] = '0;
            end
        end else if (r_byte_position != POS_MAX) begin
            n_byte_position = r_byte_position + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= '0;
            r_word_start    <= '0;
            r_char_in_word  <= '0;
            r_match_alive   <= '1;
            r_word_overflow <= 1'b0;
            for (int k = 0; k < NUM_KW; k++) begin
                r_counts[k] <= '0;
            end
        end else if (i_accept) begin
            r_byte_position <= n_byte_position;
            r_word_start    <= n_word_start;
            r_char_in_word  <= n_char_in_word;
            r_match_alive   <= n_match_alive;
            r_word_overflow <= n_word_overflow;
            for (int k = 0; k < NUM_KW; k++) begin
                r_counts[k] <= n_counts[k];
            end
        end
    end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the whole-word keyword spotter core.
`timescale 1ns / 1ps

module testbench;
    import kwsp_pkg::*;

    localparam int     DIRECTED_ROWS = 28;
    localparam int     RANDOM_ITEMS  = 750;
    localparam int     WORD_LEN_CAP  = 15;
    localparam int     DRAIN_LIMIT   = 5000;
    localparam int     SETTLE_CYCLES = 8;
    localparam longint TIMEOUT_NS    = 64'd12 * 64'd600_000;

    // One row of the directed table: the byte to send and, where it is
    // obvious, the single result it must raise.
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        t_result    ev;
    } t_stim_row;

    localparam t_result NO_EVENT = '0;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_event_kind;
    logic [1:0] o_keyword_index;
    logic [7:0] o_start_position;
    logic [3:0] o_occurrence;
    logic       o_none_found;
    logic       o_last_of_run;

    // Scanner state mirrored from the core's behaviour.
    int         scan_pos;
    int         word_begin;
    int         word_len;
    logic [2:0] live_kw;
    int         kw_hits [NUM_KW];
    bit         word_too_long;
    string      kw_word [NUM_KW] = '{"ATTACK", "MALWARE", "VIRUS"};

    t_result    fresh_events [$];   // results raised by the byte just scanned
    t_result    due_events [$];     // results the core still owes, oldest first
    logic [7:0] text_stream [$];
    t_stim_row  directed_rows [DIRECTED_ROWS];

    int tx_idle_pct  = 14;
    int rx_stall_pct = 88;
    int error_count  = 0;
    int matches_seen = 0;
    int summaries_seen = 0;
    int texts_built  = 0;

    whole_word_keyword_spotter_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_text_byte      (i_text_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_keyword_index  (o_keyword_index),
        .o_start_position (o_start_position),
        .o_occurrence     (o_occurrence),
        .o_none_found     (o_none_found),
        .o_last_of_run    (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still owed", due_events.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit is_boundary(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_DOT || c == CHAR_EXCL || c == CHAR_QUERY;
    endfunction

    function automatic void open_word();
        word_len      = 0;
        live_kw       = '1;
        word_too_long = 1'b0;
    endfunction

    function automatic void clear_scan();
        scan_pos   = 0;
        word_begin = 0;
        foreach (kw_hits[k]) kw_hits[k] = 0;
        open_word();
    endfunction

    // Advances the mirrored scanner by one byte and leaves the results that
    // byte raises in fresh_events, in the order the core must deliver them.
    function automatic void scan_byte(input logic [7:0] c);
        t_result ev;
        bit      hit;
        int      k;
        fresh_events.delete();
        hit = 1'b0;
        if (c == CHAR_NUL || is_boundary(c)) begin
            // Only the first live keyword of exactly the word's length can match.
            for (k = 0; k < NUM_KW; k++) begin
                if (!hit && live_kw[k] && !word_too_long && word_len == kw_word[k].len()) begin
                    hit = 1'b1;
                    if (kw_hits[k] < MAX_COUNT) kw_hits[k]++;
                    ev                = NO_EVENT;
                    ev.event_kind     = EV_MATCH;
                    ev.keyword_index  = 2'(k);
                    ev.start_position = 8'(word_begin);
                    ev.occurrence     = 4'(kw_hits[k]);
                    ev.last_of_run    = (c != CHAR_NUL);
                    fresh_events.push_back(ev);
                end
            end
            if (c == CHAR_NUL) begin
                ev             = NO_EVENT;
                ev.event_kind  = EV_SUMMARY;
                ev.none_found  = (kw_hits[0] == 0 && kw_hits[1] == 0 && kw_hits[2] == 0);
                ev.last_of_run = 1'b1;
                fresh_events.push_back(ev);
                clear_scan();
                return;
            end
            open_word();
        end else begin
            if (word_len == 0 && !word_too_long) word_begin = scan_pos;
            for (k = 0; k < NUM_KW; k++) begin
                if (word_len >= kw_word[k].len() || kw_word[k].getc(word_len) != c)
                    live_kw[k] = 1'b0;
            end
            if (word_len >= WORD_LEN_CAP) word_too_long = 1'b1;
            else word_len++;
        end
        if (scan_pos < TEXT_LEN - 1) scan_pos++;
    endfunction

    // A character that never ends a word; upper-case letters are favoured so
    // that near misses of the keywords turn up often.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do begin
            c = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(65, 90))
                                             : 8'($urandom_range(1, 255));
        end while (is_boundary(c));
        return c;
    endfunction

    function automatic logic [7:0] boundary_char();
        case ($urandom_range(0, 3))
            0: return CHAR_SPACE;
            1: return CHAR_DOT;
            2: return CHAR_EXCL;
            default: return CHAR_QUERY;
        endcase
    endfunction

    // Builds one text of words ended by a zero byte. Long texts run past the
    // position limit and lean on one keyword so that its count saturates.
    task automatic append_text(input bit long_text);
        logic [7:0] w [$];
        int goal, made, pick, fav, k, i, n;
        goal = long_text ? $urandom_range(270, 330) : $urandom_range(1, 60);
        fav  = $urandom_range(0, NUM_KW - 1);
        made = 0;
        while (made < goal) begin
            w.delete();
            pick = $urandom_range(0, 99);
            k = ($urandom_range(0, 99) < 60) ? fav : $urandom_range(0, NUM_KW - 1);
            if (pick < 65 || (pick >= 80 && pick < 88)) begin
                for (i = 0; i < kw_word[k].len(); i++) w.push_back(8'(kw_word[k].getc(i)));
            end
            if (pick >= 50 && pick < 65) begin
                // Near miss: one small change to an otherwise exact keyword.
                i = $urandom_range(0, w.size() - 1);
                case ($urandom_range(0, 4))
                    0: w[i] = w[i] | 8'h20;
                    1: void'(w.pop_back());
                    2: w.push_back(word_char());
                    3: w[i] = word_char();
                    default: w.push_front(word_char());
                endcase
            end else if (pick >= 65 && pick < 80) begin
                n = $urandom_range(1, 10);
                for (i = 0; i < n; i++) w.push_back(word_char());
            end else if (pick >= 80 && pick < 88) begin
                // Long word around the length cap, starting with a keyword.
                n = $urandom_range(14, 22);
                while (w.size() < n) w.push_back(word_char());
            end else if (pick >= 94) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) w.push_back(8'($urandom_range(1, 255)));
            end
            if (pick >= 88 && pick < 94) w.delete();
            foreach (w[j]) text_stream.push_back(w[j]);
            made += w.size() + 1;
            if (made >= goal && $urandom_range(0, 1) == 1) begin
                text_stream.push_back(CHAR_NUL);
                return;
            end
            text_stream.push_back(boundary_char());
        end
        text_stream.push_back(CHAR_NUL);
    endtask

    // Offers one byte as a request, with a random hold-off first, and returns
    // at the edge where the core takes it.
    task automatic send_byte(input logic [7:0] b);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        do begin
            @(negedge i_clk);
            taken = (o_stall === 1'b0);
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic flag_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input logic has_x);
        if (has_x || got != want)
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Receiver: random stall, renewed at every edge.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // A result is taken at the edge that follows a low phase in which valid
    // is high and stall is low; both are stable between edges.
    always @(negedge i_clk) begin : take_result
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (due_events.size() == 0) begin
                flag_mismatch("result delivered with nothing expected");
            end else begin
                want = due_events.pop_front();
                if (want.event_kind == EV_SUMMARY) summaries_seen++;
                else matches_seen++;
                check_field("event_kind", int'(o_event_kind), int'(want.event_kind),
                            $isunknown(o_event_kind));
                check_field("keyword_index", int'(o_keyword_index),
                            int'(want.keyword_index), $isunknown(o_keyword_index));
                check_field("start_position", int'(o_start_position),
                            int'(want.start_position), $isunknown(o_start_position));
                check_field("occurrence", int'(o_occurrence), int'(want.occurrence),
                            $isunknown(o_occurrence));
                check_field("none_found", int'(o_none_found), int'(want.none_found),
                            $isunknown(o_none_found));
                check_field("last_of_run", int'(o_last_of_run), int'(want.last_of_run),
                            $isunknown(o_last_of_run));
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        int        total, idx, waited;

        clear_scan();

        // Directed part. Positions restart at zero after each zero byte.
        directed_rows = '{
            '{CHAR_NUL,   1'b1, '{EV_SUMMARY, 2'd0, 8'd0, 4'd0, 1'b1, 1'b1}},
            '{"V",        1'b0, NO_EVENT},
            '{"I",        1'b0, NO_EVENT},
            '{"R",        1'b0, NO_EVENT},
            '{"U",        1'b0, NO_EVENT},
            '{"S",        1'b0, NO_EVENT},
            '{CHAR_SPACE, 1'b1, '{EV_MATCH, KW_VIRUS, 8'd0, 4'd1, 1'b0, 1'b1}},
            '{CHAR_DOT,   1'b0, NO_EVENT},   // empty word between two separators
            '{CHAR_QUERY, 1'b0, NO_EVENT},
            '{"A",        1'b0, NO_EVENT},
            '{"T",        1'b0, NO_EVENT},
            '{"T",        1'b0, NO_EVENT},
            '{"A",        1'b0, NO_EVENT},
            '{"C",        1'b0, NO_EVENT},
            '{"K",        1'b0, NO_EVENT},
            '{CHAR_NUL,   1'b0, NO_EVENT},   // keyword closed by the end of text
            '{8'hFF,      1'b0, NO_EVENT},
            '{8'h80,      1'b0, NO_EVENT},
            '{CHAR_EXCL,  1'b0, NO_EVENT},
            '{"M",        1'b0, NO_EVENT},
            '{"A",        1'b0, NO_EVENT},
            '{"L",        1'b0, NO_EVENT},
            '{"W",        1'b0, NO_EVENT},
            '{"A",        1'b0, NO_EVENT},
            '{"R",        1'b0, NO_EVENT},
            '{"E",        1'b0, NO_EVENT},
            '{CHAR_EXCL,  1'b1, '{EV_MATCH, KW_MALWARE, 8'd3, 4'd1, 1'b0, 1'b1}},
            '{CHAR_NUL,   1'b1, '{EV_SUMMARY, 2'd0, 8'd0, 4'd0, 1'b0, 1'b1}}
        };

        while (text_stream.size() < RANDOM_ITEMS) begin
            append_text(texts_built % 4 == 0);
            texts_built++;
        end
        total = DIRECTED_ROWS + text_stream.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < total; idx++) begin
            // Three idling phases: slow receiver, then slow sender, then none.
            if (idx == total / 3) begin
                tx_idle_pct  = 88;
                rx_stall_pct <= 14;
            end else if (idx == (2 * total) / 3) begin
                tx_idle_pct  = 0;
                rx_stall_pct <= 0;
            end
            if (idx < DIRECTED_ROWS) row = directed_rows[idx];
            else row = '{text_stream[idx - DIRECTED_ROWS], 1'b0, NO_EVENT};
            send_byte(row.ch);
            scan_byte(row.ch);
            if (row.typed) due_events.push_back(row.ev);
            else foreach (fresh_events[j]) due_events.push_back(fresh_events[j]);
        end
        i_valid <= 1'b0;

        waited = 0;
        while (due_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (due_events.size() != 0)
            flag_mismatch($sformatf("%0d results never delivered", due_events.size()));
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d text bytes (%0d directed, %0d random texts).",
                 total, DIRECTED_ROWS, texts_built);
        $display("Checked %0d keyword matches and %0d end-of-text summaries, %0d mismatches.",
                 matches_seen, summaries_seen, error_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
